// ===== rtl/core/tok_pkg.sv =====
// Shared types, constants, codepoint classifiers and other tokenizer helpers.
package tok_pkg;

  localparam int LEN_BITS = 16;
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);
  localparam int WR_PORTS = 3;

  localparam logic [1:0] UK_CLUSTER = 2'd0;
  localparam logic [1:0] UK_TAB = 2'd1;
  localparam logic [1:0] UK_CONTROL = 2'd2;
  localparam logic [1:0] UK_TRAIL = 2'd3;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CSI_FINAL_LO = 8'h40;
  localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

  localparam logic [20:0] CP_ZWJ = 21'h0200D;
  localparam logic [20:0] CP_VS16 = 21'h0FE0F;
  localparam logic [20:0] CP_KEYCAP = 21'h020E3;
  localparam logic [20:0] CP_EMOJI_LO = 21'h1F000;
  localparam logic [20:0] CP_RI_LO = 21'h1F1E6;
  localparam logic [20:0] CP_RI_HI = 21'h1F1FF;
  localparam logic [20:0] CP_MOD_LO = 21'h1F3FB;
  localparam logic [20:0] CP_MOD_HI = 21'h1F3FF;

  typedef enum logic [2:0] {
    PH_NONE, PH_ESC, PH_CSI, PH_OSC, PH_OSC_ESC, PH_CHARSET
  } esc_phase_t;

  typedef enum logic [1:0] {MD_NORMAL, MD_TAIL, MD_FINAL} tail_mode_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [15:0] text;
    logic [15:0] esc;
    logic [1:0] cols;
    logic vis;
    logic pace;
    logic line_done;
    logic run_last;
  } unit_t;

  localparam int COMB_N = 46;
  localparam logic [41:0] COMB_TAB [COMB_N] = '{
    {21'h000AD, 21'h000AD}, {21'h00300, 21'h0036F}, {21'h00483, 21'h00489},
    {21'h00591, 21'h005BD}, {21'h005BF, 21'h005BF}, {21'h005C7, 21'h005C7},
    {21'h005C1, 21'h005C2}, {21'h005C4, 21'h005C5}, {21'h00610, 21'h0061A},
    {21'h0064B, 21'h0065F}, {21'h00670, 21'h00670}, {21'h006D6, 21'h006DC},
    {21'h006DF, 21'h006E4}, {21'h006E7, 21'h006E8}, {21'h006EA, 21'h006ED},
    {21'h00711, 21'h00711}, {21'h00730, 21'h0074A}, {21'h007A6, 21'h007B0},
    {21'h00900, 21'h00902}, {21'h0093A, 21'h0093A}, {21'h00941, 21'h00948},
    {21'h00962, 21'h00963}, {21'h01AB0, 21'h01AFF}, {21'h01DC0, 21'h01DFF},
    {21'h020D0, 21'h020FF}, {21'h0FE20, 21'h0FE2F}, {21'h00600, 21'h00605},
    {21'h0061C, 21'h0061C}, {21'h006DD, 21'h006DD}, {21'h0070F, 21'h0070F},
    {21'h00890, 21'h00891}, {21'h008E2, 21'h008E2}, {21'h0180E, 21'h0180E},
    {21'h0200B, 21'h0200F}, {21'h0202A, 21'h0202E}, {21'h02060, 21'h02064},
    {21'h02066, 21'h0206F}, {21'h0FEFF, 21'h0FEFF}, {21'h0FFF9, 21'h0FFFB},
    {21'h110BD, 21'h110BD}, {21'h110CD, 21'h110CD}, {21'h13430, 21'h1343F},
    {21'h1BCA0, 21'h1BCA3}, {21'h1D173, 21'h1D17A}, {21'hE0001, 21'hE0001},
    {21'hE0020, 21'hE007F}
  };

  localparam int WIDE_N = 54;
  localparam logic [41:0] WIDE_TAB [WIDE_N] = '{
    {21'h01100, 21'h0115F}, {21'h0A960, 21'h0A97C}, {21'h0AC00, 21'h0D7A3},
    {21'h0D7B0, 21'h0D7FF}, {21'h02E80, 21'h0303E}, {21'h03040, 21'h033BF},
    {21'h03400, 21'h04DBF}, {21'h04E00, 21'h0A4CF}, {21'h0F900, 21'h0FAFF},
    {21'h20000, 21'h3FFFF}, {21'h0FE10, 21'h0FE19}, {21'h0FE30, 21'h0FE6F},
    {21'h0FF01, 21'h0FF60}, {21'h0FFE0, 21'h0FFE6}, {21'h1B000, 21'h1B0FF},
    {21'h0231A, 21'h0231B}, {21'h02329, 21'h0232A}, {21'h023E9, 21'h023EC},
    {21'h023F0, 21'h023F0}, {21'h023F3, 21'h023F3}, {21'h025FD, 21'h025FE},
    {21'h02614, 21'h02615}, {21'h02630, 21'h02637}, {21'h02648, 21'h02653},
    {21'h0267F, 21'h0267F}, {21'h0268A, 21'h0268F}, {21'h02693, 21'h02693},
    {21'h026A1, 21'h026A1}, {21'h026AA, 21'h026AB}, {21'h026BD, 21'h026BE},
    {21'h026C4, 21'h026C5}, {21'h026CE, 21'h026CE}, {21'h026D4, 21'h026D4},
    {21'h026EA, 21'h026EA}, {21'h026F2, 21'h026F3}, {21'h026F5, 21'h026F5},
    {21'h026FA, 21'h026FA}, {21'h026FD, 21'h026FD}, {21'h02705, 21'h02705},
    {21'h0270A, 21'h0270B}, {21'h02728, 21'h02728}, {21'h0274C, 21'h0274C},
    {21'h0274E, 21'h0274E}, {21'h02753, 21'h02755}, {21'h02757, 21'h02757},
    {21'h02795, 21'h02797}, {21'h027B0, 21'h027B0}, {21'h027BF, 21'h027BF},
    {21'h02B1B, 21'h02B1C}, {21'h02B50, 21'h02B50}, {21'h02B55, 21'h02B55},
    {21'h1F004, 21'h1F9FF}, {21'h1F170, 21'h1F1FF}, {21'h1FA00, 21'h1FAFF}
  };

  function automatic logic is_comb(input logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < COMB_N; i++) begin
      hit = hit | ((cp >= COMB_TAB[i][41:21]) && (cp <= COMB_TAB[i][20:0]));
    end
    return hit;
  endfunction

  function automatic logic is_wide(input logic [20:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < WIDE_N; i++) begin
      hit = hit | ((cp >= WIDE_TAB[i][41:21]) && (cp <= WIDE_TAB[i][20:0]));
    end
    return hit;
  endfunction

  function automatic logic is_vs(input logic [20:0] cp);
    return ((cp >= 21'h0FE00) && (cp <= 21'h0FE0F)) ||
           ((cp >= 21'hE0100) && (cp <= 21'hE01EF));
  endfunction

  function automatic logic is_ri(input logic [20:0] cp);
    return (cp >= CP_RI_LO) && (cp <= CP_RI_HI);
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    if (b[7] == 1'b0) n = 3'd1;
    else if (b[7:5] == 3'b110) n = 3'd2;
    else if (b[7:4] == 4'b1110) n = 3'd3;
    else if (b[7:3] == 5'b11110) n = 3'd4;
    else n = 3'd1;
    return n;
  endfunction

  function automatic logic [20:0] decode(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [2:0] need);
    logic [20:0] cp;
    case (need)
      3'd2: cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      3'd4: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [2:0] n);
    logic [16:0] s;
    s = {1'b0, a} + {14'd0, n};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic unit_t mk_unit(input logic [1:0] kind, input logic [15:0] text,
                                    input logic [15:0] esc, input logic [1:0] cols,
                                    input logic vis);
    unit_t u;
    u.kind = kind;
    u.text = text;
    u.esc = esc;
    u.cols = cols;
    u.vis = vis;
    u.pace = vis;
    u.line_done = 1'b0;
    u.run_last = 1'b0;
    return u;
  endfunction

endpackage

// ===== rtl/core/terminal_unit_tokenizer_unit.sv =====
// Top level of the terminal line tokenizer: byte queue in, unit queue out.
// Bytes are taken one per clock while the front end is not full. The last byte of a line
// holds the input while the front end walks the line tail (the byte plus up to three held
// UTF-8 bytes) one codepoint or escape byte at a time, and then while it closes the line.
// Units wait in an eight-entry queue, and input stalls while fewer than three entries are
// free. A unit is written to the queue with the item that completes it and appears on the
// output in the cycle after, later for line ends.
module terminal_unit_tokenizer_unit (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [7:0] data_byte,
  input  logic line_end,
  input  logic pop,
  output logic empty,
  output logic [1:0] unit_kind,
  output logic [15:0] text_length,
  output logic [15:0] escape_length,
  output logic [1:0] columns,
  output logic is_visible,
  output logic paces,
  output logic line_done,
  output logic run_last
);

  logic room;
  logic [1:0] wr_cnt;
  tok_pkg::unit_t wr_unit [tok_pkg::WR_PORTS];
  tok_pkg::unit_t head;

  tok_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .data_byte(data_byte),
    .line_end(line_end), .room(room), .wr_cnt(wr_cnt), .wr_unit(wr_unit)
  );

  tok_queue u_queue (
    .clk(clk), .rst(rst), .wr_cnt(wr_cnt), .wr_unit(wr_unit), .room(room),
    .pop(pop), .empty(empty), .head(head)
  );

  assign unit_kind = head.kind;
  assign text_length = head.text;
  assign escape_length = head.esc;
  assign columns = head.cols;
  assign is_visible = head.vis;
  assign paces = head.pace;
  assign line_done = head.line_done;
  assign run_last = head.run_last;

endmodule

// ===== rtl/core/tok_front.sv =====
// Front end: accepts bytes, tracks escapes and UTF-8, groups clusters and emits units.
module tok_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [7:0] data_byte,
  input  logic line_end,
  input  logic room,
  output logic [1:0] wr_cnt,
  output tok_pkg::unit_t wr_unit [tok_pkg::WR_PORTS]
);

  tok_pkg::tail_mode_t mode, mode_next;
  tok_pkg::esc_phase_t phase, phase_next;
  logic [15:0] esc_count, esc_count_next;
  logic [7:0] pbytes [3];
  logic [7:0] pbytes_next [3];
  logic [1:0] pcount, pcount_next;
  logic c_open, c_open_next;
  logic [15:0] c_bytes, c_bytes_next;
  logic c_emoji, c_emoji_next;
  logic [1:0] c_wsum, c_wsum_next;
  logic prev_ri, prev_ri_next;
  logic absorb, absorb_next;
  logic [7:0] tbuf [4];
  logic [7:0] tbuf_next [4];
  logic [2:0] tcnt, tcnt_next;
  tok_pkg::unit_t hold, hold_next;
  logic hold_valid, hold_valid_next;

  assign full = (mode != tok_pkg::MD_NORMAL) || !room;

  always_comb begin : engine
    logic accept;
    logic do_cp;
    logic do_esc;
    logic do_add;
    logic handled;
    logic step_end;
    logic is_final;
    logic [7:0] eb;
    logic [7:0] nb [4];
    logic [2:0] need;
    logic [20:0] cp;
    logic [2:0] n;
    logic [1:0] u_cnt;
    logic [1:0] nl;
    logic [2:0] wtmp;
    tok_pkg::unit_t u [2];
    tok_pkg::unit_t e [3];

    mode_next = mode;
    phase_next = phase;
    esc_count_next = esc_count;
    pbytes_next = pbytes;
    pcount_next = pcount;
    c_open_next = c_open;
    c_bytes_next = c_bytes;
    c_emoji_next = c_emoji;
    c_wsum_next = c_wsum;
    prev_ri_next = prev_ri;
    absorb_next = absorb;
    tbuf_next = tbuf;
    tcnt_next = tcnt;
    hold_next = hold;
    hold_valid_next = hold_valid;
    accept = push && !full;
    do_cp = 1'b0;
    do_esc = 1'b0;
    do_add = 1'b0;
    handled = 1'b0;
    step_end = 1'b0;
    is_final = 1'b0;
    eb = data_byte;
    need = 3'd1;
    cp = '0;
    n = 3'd1;
    u_cnt = 2'd0;
    u[0] = '0;
    u[1] = '0;
    nb[0] = (pcount == 2'd0) ? data_byte : pbytes[0];
    nb[1] = (pcount == 2'd1) ? data_byte : pbytes[1];
    nb[2] = (pcount == 2'd2) ? data_byte : pbytes[2];
    nb[3] = (pcount == 2'd3) ? data_byte : 8'd0;

    if (mode == tok_pkg::MD_NORMAL) begin
      if (accept && line_end) begin
        tbuf_next = nb;
        tcnt_next = {1'b0, pcount} + 3'd1;
        pcount_next = 2'd0;
        mode_next = tok_pkg::MD_TAIL;
      end else if (accept) begin
        step_end = 1'b1;
        if (phase != tok_pkg::PH_NONE) begin
          do_esc = 1'b1;
        end else if (pcount != 2'd0) begin
          need = tok_pkg::lead_len(pbytes[0]);
          if ({1'b0, pcount} + 3'd1 >= need) begin
            cp = tok_pkg::decode(nb[0], nb[1], nb[2], nb[3], need);
            n = need;
            do_cp = 1'b1;
            pcount_next = 2'd0;
          end else begin
            pbytes_next[pcount] = data_byte;
            pcount_next = pcount + 2'd1;
          end
        end else if (tok_pkg::lead_len(data_byte) == 3'd1) begin
          cp = {13'd0, data_byte};
          do_cp = 1'b1;
        end else begin
          pbytes_next[0] = data_byte;
          pcount_next = 2'd1;
        end
      end
    end else if (mode == tok_pkg::MD_TAIL && room) begin
      if (phase != tok_pkg::PH_NONE) begin
        do_esc = 1'b1;
        eb = tbuf[0];
      end else begin
        need = tok_pkg::lead_len(tbuf[0]);
        if (need == 3'd1 || need > tcnt) begin
          cp = {13'd0, tbuf[0]};
        end else begin
          cp = tok_pkg::decode(tbuf[0], tbuf[1], tbuf[2], tbuf[3], need);
          n = need;
        end
        do_cp = 1'b1;
      end
      case (n)
        3'd1: tbuf_next = '{tbuf[1], tbuf[2], tbuf[3], 8'd0};
        3'd2: tbuf_next = '{tbuf[2], tbuf[3], 8'd0, 8'd0};
        3'd3: tbuf_next = '{tbuf[3], 8'd0, 8'd0, 8'd0};
        default: tbuf_next = '{8'd0, 8'd0, 8'd0, 8'd0};
      endcase
      tcnt_next = (tcnt > n) ? (tcnt - n) : 3'd0;
      if (tcnt <= n) mode_next = tok_pkg::MD_FINAL;
    end else if (mode == tok_pkg::MD_FINAL && room) begin
      step_end = 1'b1;
      is_final = 1'b1;
      if (c_open) begin
        u[0] = tok_pkg::mk_unit(tok_pkg::UK_CLUSTER, c_bytes, esc_count,
                                c_emoji ? 2'd2 : ((c_wsum != 2'd0) ? c_wsum : 2'd1), 1'b1);
        u_cnt = 2'd1;
      end else if (esc_count != 16'd0) begin
        u[0] = tok_pkg::mk_unit(tok_pkg::UK_TRAIL, 16'd0, esc_count, 2'd0, 1'b0);
        u_cnt = 2'd1;
      end
      phase_next = tok_pkg::PH_NONE;
      esc_count_next = 16'd0;
      pcount_next = 2'd0;
      c_open_next = 1'b0;
      c_bytes_next = 16'd0;
      c_emoji_next = 1'b0;
      c_wsum_next = 2'd0;
      prev_ri_next = 1'b0;
      absorb_next = 1'b0;
      mode_next = tok_pkg::MD_NORMAL;
    end

    if (do_esc) begin
      esc_count_next = tok_pkg::sat_add(esc_count, 3'd1);
      unique case (phase)
        tok_pkg::PH_ESC: begin
          if (eb == tok_pkg::CH_LBRACKET) phase_next = tok_pkg::PH_CSI;
          else if (eb == tok_pkg::CH_RBRACKET) phase_next = tok_pkg::PH_OSC;
          else if (eb == tok_pkg::CH_LPAREN || eb == tok_pkg::CH_RPAREN ||
                   eb == tok_pkg::CH_HASH || eb == tok_pkg::CH_PERCENT)
            phase_next = tok_pkg::PH_CHARSET;
          else phase_next = tok_pkg::PH_NONE;
        end
        tok_pkg::PH_CSI: begin
          if (eb >= tok_pkg::CSI_FINAL_LO && eb <= tok_pkg::CSI_FINAL_HI)
            phase_next = tok_pkg::PH_NONE;
        end
        tok_pkg::PH_OSC_ESC: begin
          if (eb == tok_pkg::CH_BSLASH || eb == tok_pkg::CH_BEL) phase_next = tok_pkg::PH_NONE;
          else if (eb != tok_pkg::CH_ESC) phase_next = tok_pkg::PH_OSC;
        end
        tok_pkg::PH_OSC: begin
          if (eb == tok_pkg::CH_BEL) phase_next = tok_pkg::PH_NONE;
          else if (eb == tok_pkg::CH_ESC) phase_next = tok_pkg::PH_OSC_ESC;
        end
        default: phase_next = tok_pkg::PH_NONE;
      endcase
    end

    if (do_cp) begin
      if (c_open) begin
        if (absorb) begin
          do_add = 1'b1;
          absorb_next = 1'b0;
          prev_ri_next = tok_pkg::is_ri(cp);
          handled = 1'b1;
        end else if (cp == tok_pkg::CP_ZWJ) begin
          do_add = 1'b1;
          absorb_next = 1'b1;
          prev_ri_next = 1'b0;
          handled = 1'b1;
        end else if (tok_pkg::is_comb(cp) || tok_pkg::is_vs(cp) ||
                     (cp >= tok_pkg::CP_MOD_LO && cp <= tok_pkg::CP_MOD_HI) ||
                     cp == tok_pkg::CP_KEYCAP || (prev_ri && tok_pkg::is_ri(cp))) begin
          do_add = 1'b1;
          prev_ri_next = tok_pkg::is_ri(cp);
          handled = 1'b1;
        end else begin
          u[0] = tok_pkg::mk_unit(tok_pkg::UK_CLUSTER, c_bytes, esc_count_next,
                                  c_emoji ? 2'd2 : ((c_wsum != 2'd0) ? c_wsum : 2'd1), 1'b1);
          u_cnt = 2'd1;
          esc_count_next = 16'd0;
          c_open_next = 1'b0;
          c_bytes_next = 16'd0;
          c_emoji_next = 1'b0;
          c_wsum_next = 2'd0;
          prev_ri_next = 1'b0;
          absorb_next = 1'b0;
        end
      end
      if (!handled) begin
        if (n == 3'd1 && cp == {13'd0, tok_pkg::CH_ESC}) begin
          phase_next = tok_pkg::PH_ESC;
          esc_count_next = tok_pkg::sat_add(esc_count_next, 3'd1);
        end else if (n == 3'd1 && cp == {13'd0, tok_pkg::CH_TAB}) begin
          u[u_cnt[0]] = tok_pkg::mk_unit(tok_pkg::UK_TAB, 16'd1, esc_count_next, 2'd1, 1'b1);
          u_cnt = u_cnt + 2'd1;
          esc_count_next = 16'd0;
        end else if (n == 3'd1 && (cp < {13'd0, tok_pkg::CH_SPACE} ||
                                   cp == {13'd0, tok_pkg::CH_DEL})) begin
          u[u_cnt[0]] = tok_pkg::mk_unit(tok_pkg::UK_CONTROL, 16'd1, esc_count_next,
                                         2'd0, 1'b0);
          u_cnt = u_cnt + 2'd1;
          esc_count_next = 16'd0;
        end else begin
          c_open_next = 1'b1;
          c_bytes_next = 16'd0;
          c_emoji_next = 1'b0;
          c_wsum_next = 2'd0;
          absorb_next = 1'b0;
          do_add = 1'b1;
          prev_ri_next = tok_pkg::is_ri(cp);
        end
      end
      if (do_add) begin
        c_bytes_next = tok_pkg::sat_add(c_bytes_next, n);
        if (cp == tok_pkg::CP_VS16 || cp == tok_pkg::CP_ZWJ || cp >= tok_pkg::CP_EMOJI_LO)
          c_emoji_next = 1'b1;
        if (!(tok_pkg::is_comb(cp) || tok_pkg::is_vs(cp) || cp == tok_pkg::CP_ZWJ)) begin
          wtmp = {1'b0, c_wsum_next} + (tok_pkg::is_wide(cp) ? 3'd2 : 3'd1);
          c_wsum_next = (wtmp > 3'd2) ? 2'd2 : wtmp[1:0];
        end
      end
    end

    if (hold_valid) begin
      e[0] = hold;
      e[1] = u[0];
      e[2] = u[1];
    end else begin
      e[0] = u[0];
      e[1] = u[1];
      e[2] = '0;
    end
    nl = {1'b0, hold_valid} + u_cnt;
    wr_cnt = 2'd0;
    if (step_end) begin
      wr_cnt = nl;
      hold_valid_next = 1'b0;
      for (int i = 0; i < tok_pkg::WR_PORTS; i++) begin
        if (nl != 2'd0 && i == int'(nl) - 1) begin
          e[i].run_last = 1'b1;
          e[i].line_done = is_final;
        end
      end
    end else if (nl != 2'd0) begin
      wr_cnt = nl - 2'd1;
      hold_valid_next = 1'b1;
      hold_next = e[nl - 2'd1];
    end
    wr_unit = e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= tok_pkg::MD_NORMAL;
      phase <= tok_pkg::PH_NONE;
      esc_count <= 16'd0;
      pcount <= 2'd0;
      c_open <= 1'b0;
      c_bytes <= 16'd0;
      c_emoji <= 1'b0;
      c_wsum <= 2'd0;
      prev_ri <= 1'b0;
      absorb <= 1'b0;
      tcnt <= 3'd0;
      hold_valid <= 1'b0;
    end else begin
      mode <= mode_next;
      phase <= phase_next;
      esc_count <= esc_count_next;
      pcount <= pcount_next;
      c_open <= c_open_next;
      c_bytes <= c_bytes_next;
      c_emoji <= c_emoji_next;
      c_wsum <= c_wsum_next;
      prev_ri <= prev_ri_next;
      absorb <= absorb_next;
      tcnt <= tcnt_next;
      hold_valid <= hold_valid_next;
    end
    pbytes <= pbytes_next;
    tbuf <= tbuf_next;
    hold <= hold_next;
  end

endmodule

// ===== rtl/core/tok_queue.sv =====
// Back end: result queue that takes up to three units a cycle and hands out one.
module tok_queue (
  input  logic clk,
  input  logic rst,
  input  logic [1:0] wr_cnt,
  input  tok_pkg::unit_t wr_unit [tok_pkg::WR_PORTS],
  output logic room,
  input  logic pop,
  output logic empty,
  output tok_pkg::unit_t head
);

  tok_pkg::unit_t mem [tok_pkg::Q_DEPTH];
  logic [tok_pkg::Q_PTR_BITS-1:0] wptr, rptr;
  logic [tok_pkg::Q_CNT_BITS-1:0] count, count_next;
  logic take;

  assign empty = (count == '0);
  assign take = pop && !empty;
  assign head = mem[rptr];
  assign room = (count <= tok_pkg::Q_CNT_BITS'(tok_pkg::Q_DEPTH - tok_pkg::WR_PORTS));
  assign count_next = count + tok_pkg::Q_CNT_BITS'(wr_cnt) - tok_pkg::Q_CNT_BITS'(take);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + tok_pkg::Q_PTR_BITS'(wr_cnt);
      rptr <= rptr + tok_pkg::Q_PTR_BITS'(take);
      count <= count_next;
    end
    for (int i = 0; i < tok_pkg::WR_PORTS; i++) begin
      if (i < int'(wr_cnt)) mem[wptr + tok_pkg::Q_PTR_BITS'(i)] <= wr_unit[i];
    end
  end

endmodule

// ===== rtl/core/tok_checker.sv =====
// Port-level assertions for the tokenizer and their bind to the top level.
module tok_checker (
  input logic clk,
  input logic rst,
  input logic empty,
  input logic [1:0] unit_kind,
  input logic [15:0] text_length,
  input logic [1:0] columns,
  input logic is_visible,
  input logic line_done,
  input logic run_last
);

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result queue not empty after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && line_done) |-> run_last)
    else $error("line end item is not the last of its byte");

  a_trail_no_text: assert property (@(posedge clk) disable iff (rst)
    (!empty && unit_kind == tok_pkg::UK_TRAIL) |-> (text_length == 16'd0 && !is_visible))
    else $error("trailing escape item carries text");

  a_columns: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (columns != 2'd3 && (is_visible || columns == 2'd0)))
    else $error("bad column count");

endmodule

bind terminal_unit_tokenizer_unit tok_checker u_tok_checker (.*);
